// File: hdl/assert_macros.svh
// Assertion macros shared by the multitouch slot tracker RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MST_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define MST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define MST_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MST_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/mst_pkg.sv
// Types, codes and helper functions of the multitouch slot tracker.
// Used by mst_scale_div and multitouch_slot_event_tracker_top.
package mst_pkg;

	localparam int RAW_W    = 16;
	localparam int SCREEN_W = 14;
	localparam int QUOT_W   = RAW_W + SCREEN_W;
	localparam int POS_W    = 13;
	localparam int FINGER_W = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Event types and codes.
	localparam logic [4:0] EV_SYN = 5'd0;
	localparam logic [4:0] EV_ABS = 5'd3;
	localparam logic [9:0] CODE_SYN_REPORT = 10'h000;
	localparam logic [9:0] CODE_SLOT = 10'h02F;
	localparam logic [9:0] CODE_POS_X = 10'h035;
	localparam logic [9:0] CODE_POS_Y = 10'h036;

	// Result kinds.
	localparam logic [1:0] KIND_DOWN   = 2'd0;
	localparam logic [1:0] KIND_MOTION = 2'd1;
	localparam logic [1:0] KIND_UP     = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOUCH_X_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TOUCH_Y_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y      = 3'd5;

	localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RESET  = 14'd1024;
	localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RESET = 14'd768;
	localparam logic [RAW_W-1:0]    LIMIT_RESET         = 16'd4095;
	localparam logic [RAW_W-1:0]    RAW_MAX             = 16'hFFFF;

	typedef struct packed {
		logic                start;
		logic [RAW_W-1:0]    raw;
		logic [SCREEN_W-1:0] scale;
		logic [RAW_W-1:0]    limit;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
	} div_rsp_t;

	// Adds the calibration to a scaled coordinate and clamps it to the screen.
	function automatic logic [POS_W-1:0] clamp_pos(input logic [QUOT_W-1:0] quot,
		input logic signed [SCREEN_W-1:0] off, input logic [SCREEN_W-1:0] screen);
		logic signed [31:0] v;
		logic [POS_W-1:0]   hi;
		logic [POS_W-1:0]   res;
		v = $signed({2'b00, quot}) + $signed({{(32-SCREEN_W){off[SCREEN_W-1]}}, off});
		hi = (screen > 14'd8192) ? 13'd8191 : POS_W'(screen - 14'd1);
		if (screen == '0 || v < 0) begin
			res = '0;
		end else if (v > $signed({19'd0, hi})) begin
			res = hi;
		end else begin
			res = v[POS_W-1:0];
		end
		return res;
	endfunction

endpackage

// File: hdl/mst_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mst_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// File: hdl/mst_scale_div.sv
// Shared scaling unit: multiplies a raw coordinate by the screen size, then
// divides by the sensor limit one quotient bit per cycle. Uses mst_pkg.
module mst_scale_div (
	input  logic              clk,
	input  logic              arst_n,
	input  mst_pkg::div_req_t req,
	output mst_pkg::div_rsp_t rsp
);
	import mst_pkg::*;

	localparam int CNT_W = $clog2(QUOT_W + 1);

	logic              run_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [QUOT_W-1:0] quo_q;
	logic [RAW_W-1:0]  rem_q;
	logic [RAW_W-1:0]  dvs_q;
	logic [RAW_W:0]    shifted;
	logic [RAW_W:0]    diff;
	logic              sub_ok;

	assign shifted = {rem_q, quo_q[QUOT_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign sub_ok  = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(QUOT_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The product is registered in the dividend before the first step.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= {{SCREEN_W{1'b0}}, req.raw} * {{RAW_W{1'b0}}, req.scale};
			rem_q <= '0;
			dvs_q <= (req.limit == '0) ? RAW_W'(1) : req.limit;
		end else if (run_q) begin
			rem_q <= sub_ok ? diff[RAW_W-1:0] : shifted[RAW_W-1:0];
			quo_q <= {quo_q[QUOT_W-2:0], sub_ok};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
endmodule

// File: hdl/multitouch_slot_event_tracker_top.sv
// Top level of the multitouch slot tracker: event decode, slot stores,
// sync-report sequencer and result register. Uses mst_pkg, mst_ram, mst_scale_div.
`include "assert_macros.svh"

// Slot, position and other absolute events are taken while the block is idle. A sync
// report walks every slot: a slot that was not reported is passed over, while both
// coordinates of a reported slot go one after the other through a single bit-serial
// divider of 30 steps. A second walk over all slots finds the lifted fingers, and
// every result can wait in the emit state while the output side stalls. The block
// stalls its input for the whole walk. Results are handed over through an output
// register, so the next event is taken while the last one waits.
module multitouch_slot_event_tracker_top #(
	parameter int MAX_SLOTS = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       cfg_valid,
	output logic                                       cfg_ready,
	input  logic [mst_pkg::CFG_IDX_W-1:0]              cfg_index,
	input  logic [mst_pkg::CFG_DATA_W-1:0]             cfg_data,
	input  logic                                       in_valid,
	output logic                                       in_stall,
	input  logic [4:0]                                 event_type,
	input  logic [9:0]                                 event_code,
	input  logic signed [31:0]                         event_value,
	output logic                                       out_valid,
	input  logic                                       out_stall,
	output logic [1:0]                                 touch_kind,
	output logic [mst_pkg::FINGER_W-1:0]               finger_id,
	output logic [mst_pkg::POS_W-1:0]                  pos_x,
	output logic [mst_pkg::POS_W-1:0]                  pos_y,
	output logic                                       last_of_run
);
	import mst_pkg::*;

	localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_SLOTS - 1);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_SCAN   = 9'b000000010,
		S_STARTX = 9'b000000100,
		S_DIVX   = 9'b000001000,
		S_DIVY   = 9'b000010000,
		S_DECIDE = 9'b000100000,
		S_EMIT   = 9'b001000000,
		S_UPSCAN = 9'b010000000,
		S_FLUSH  = 9'b100000000
	} state_t;

	state_t state_q, state_d, walk_next;

	// Configuration.
	logic [SCREEN_W-1:0]        scr_w_q, scr_h_q;
	logic [RAW_W-1:0]           lim_x_q, lim_y_q;
	logic signed [SCREEN_W-1:0] off_x_q, off_y_q;

	// Frame and slot state.
	logic [SLOT_W-1:0]    sel_slot_q;
	logic                 sel_ok_q;
	logic [MAX_SLOTS-1:0] pending_q;
	logic [MAX_SLOTS-1:0] active_q;
	logic [SLOT_W-1:0]    slot_q;
	logic                 phase_q;

	// Work and result registers.
	logic [POS_W-1:0]    x_q, y_q;
	logic [1:0]          new_kind_q;
	logic [POS_W-1:0]    new_x_q, new_y_q;
	logic                hold_v_q;
	logic [1:0]          hold_kind_q;
	logic [SLOT_W-1:0]   hold_id_q;
	logic [POS_W-1:0]    hold_x_q, hold_y_q;
	logic                out_valid_q;
	logic [1:0]          kind_q;
	logic [FINGER_W-1:0] id_q;
	logic [POS_W-1:0]    pos_x_q, pos_y_q;
	logic                last_q;

	// Decode.
	logic             acc, is_abs, is_pos_x, is_pos_y, is_sync, pos_ok, first_pos;
	logic             slot_val_ok;
	logic [RAW_W-1:0] raw_sat;
	logic             adv, last_slot, out_free, load_out, load_last, take_new;

	logic [RAW_W-1:0]     raw_x_rd, raw_y_rd;
	logic [2*POS_W-1:0]   last_rd;
	div_req_t             dreq;
	div_rsp_t             drsp;
	logic [POS_W-1:0]     div_pos;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);

	assign acc       = in_valid && !in_stall;
	assign is_abs    = (event_type == EV_ABS);
	assign is_pos_x  = is_abs && (event_code == CODE_POS_X);
	assign is_pos_y  = is_abs && (event_code == CODE_POS_Y);
	assign is_sync   = (event_type == EV_SYN) && (event_code == CODE_SYN_REPORT);
	assign pos_ok    = acc && (is_pos_x || is_pos_y) && sel_ok_q;
	assign first_pos = !pending_q[sel_slot_q];
	assign slot_val_ok = !event_value[31] && (event_value[30:0] < 31'(MAX_SLOTS));
	assign raw_sat   = event_value[31] ? '0 :
		((|event_value[30:RAW_W]) ? RAW_MAX : event_value[RAW_W-1:0]);

	assign last_slot = (slot_q == SLOT_LAST);
	assign out_free  = !out_valid_q || !out_stall;

	// A coordinate that is not reported in the frame reads as zero.
	mst_ram #(.WIDTH(RAW_W), .DEPTH(MAX_SLOTS)) u_raw_x_ram (
		.clk   (clk),
		.we    (pos_ok && (is_pos_x || first_pos)),
		.waddr (sel_slot_q),
		.wdata (is_pos_x ? raw_sat : '0),
		.raddr (slot_q),
		.rdata (raw_x_rd)
	);

	mst_ram #(.WIDTH(RAW_W), .DEPTH(MAX_SLOTS)) u_raw_y_ram (
		.clk   (clk),
		.we    (pos_ok && (is_pos_y || first_pos)),
		.waddr (sel_slot_q),
		.wdata (is_pos_y ? raw_sat : '0),
		.raddr (slot_q),
		.rdata (raw_y_rd)
	);

	mst_ram #(.WIDTH(2 * POS_W), .DEPTH(MAX_SLOTS)) u_last_ram (
		.clk   (clk),
		.we    (state_q == S_DECIDE),
		.waddr (slot_q),
		.wdata ({x_q, y_q}),
		.raddr (slot_q),
		.rdata (last_rd)
	);

	always_comb begin
		dreq.start = (state_q == S_STARTX) || ((state_q == S_DIVX) && drsp.done);
		if (state_q == S_STARTX) begin
			dreq.raw   = raw_x_rd;
			dreq.scale = scr_w_q;
			dreq.limit = lim_x_q;
		end else begin
			dreq.raw   = raw_y_rd;
			dreq.scale = scr_h_q;
			dreq.limit = lim_y_q;
		end
	end

	mst_scale_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign div_pos = (state_q == S_DIVX) ? clamp_pos(drsp.quot, off_x_q, scr_w_q)
		: clamp_pos(drsp.quot, off_y_q, scr_h_q);

	always_comb begin
		if (last_slot) begin
			walk_next = phase_q ? S_FLUSH : S_UPSCAN;
		end else begin
			walk_next = phase_q ? S_UPSCAN : S_SCAN;
		end
	end

	always_comb begin
		state_d   = state_q;
		adv       = 1'b0;
		load_out  = 1'b0;
		load_last = 1'b0;
		take_new  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (acc && is_sync) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (pending_q[slot_q]) begin
					state_d = S_STARTX;
				end else begin
					adv     = 1'b1;
					state_d = walk_next;
				end
			end
			S_STARTX: state_d = S_DIVX;
			S_DIVX: begin
				if (drsp.done) begin
					state_d = S_DIVY;
				end
			end
			S_DIVY: begin
				if (drsp.done) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (!active_q[slot_q] || last_rd != {x_q, y_q}) begin
					state_d = S_EMIT;
				end else begin
					adv     = 1'b1;
					state_d = walk_next;
				end
			end
			S_EMIT: begin
				// The newest result waits in the hold stage until we know
				// whether another one follows it.
				if (!hold_v_q) begin
					take_new = 1'b1;
				end else if (out_free) begin
					take_new = 1'b1;
					load_out = 1'b1;
				end
				if (take_new) begin
					adv     = 1'b1;
					state_d = walk_next;
				end
			end
			S_UPSCAN: begin
				if (active_q[slot_q] && !pending_q[slot_q]) begin
					state_d = S_EMIT;
				end else begin
					adv     = 1'b1;
					state_d = walk_next;
				end
			end
			S_FLUSH: begin
				if (!hold_v_q) begin
					state_d = S_IDLE;
				end else if (out_free) begin
					load_out  = 1'b1;
					load_last = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			scr_w_q     <= SCREEN_WIDTH_RESET;
			scr_h_q     <= SCREEN_HEIGHT_RESET;
			lim_x_q     <= LIMIT_RESET;
			lim_y_q     <= LIMIT_RESET;
			off_x_q     <= '0;
			off_y_q     <= '0;
			sel_slot_q  <= '0;
			sel_ok_q    <= 1'b1;
			pending_q   <= '0;
			active_q    <= '0;
			slot_q      <= '0;
			phase_q     <= 1'b0;
			hold_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SCREEN_WIDTH:  scr_w_q <= cfg_data[SCREEN_W-1:0];
					REG_SCREEN_HEIGHT: scr_h_q <= cfg_data[SCREEN_W-1:0];
					REG_TOUCH_X_LIMIT: lim_x_q <= cfg_data;
					REG_TOUCH_Y_LIMIT: lim_y_q <= cfg_data;
					REG_OFFSET_X:      off_x_q <= $signed(cfg_data[SCREEN_W-1:0]);
					REG_OFFSET_Y:      off_y_q <= $signed(cfg_data[SCREEN_W-1:0]);
					default: ;
				endcase
			end

			// A bad slot number keeps the old slot but blocks position beats.
			if (acc && is_abs && event_code == CODE_SLOT) begin
				sel_ok_q <= slot_val_ok;
				if (slot_val_ok) begin
					sel_slot_q <= event_value[SLOT_W-1:0];
				end
			end
			if (pos_ok) begin
				pending_q[sel_slot_q] <= 1'b1;
			end

			if (acc && is_sync) begin
				slot_q  <= '0;
				phase_q <= 1'b0;
			end else if (adv) begin
				slot_q <= last_slot ? '0 : slot_q + 1'b1;
				if (last_slot) begin
					phase_q <= 1'b1;
				end
			end

			if (state_q == S_DECIDE) begin
				active_q[slot_q] <= 1'b1;
			end
			if (state_q == S_UPSCAN && active_q[slot_q] && !pending_q[slot_q]) begin
				active_q[slot_q] <= 1'b0;
			end
			if (state_q == S_FLUSH && state_d == S_IDLE) begin
				pending_q <= '0;
			end

			if (take_new) begin
				hold_v_q <= 1'b1;
			end else if (load_last) begin
				hold_v_q <= 1'b0;
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DIVX && drsp.done) begin
			x_q <= div_pos;
		end
		if (state_q == S_DIVY && drsp.done) begin
			y_q <= div_pos;
		end
		if (state_q == S_DECIDE) begin
			new_kind_q <= active_q[slot_q] ? KIND_MOTION : KIND_DOWN;
			new_x_q    <= x_q;
			new_y_q    <= y_q;
		end
		if (state_q == S_UPSCAN) begin
			new_kind_q <= KIND_UP;
			new_x_q    <= '0;
			new_y_q    <= '0;
		end
		if (take_new) begin
			hold_kind_q <= new_kind_q;
			hold_id_q   <= slot_q;
			hold_x_q    <= new_x_q;
			hold_y_q    <= new_y_q;
		end
		if (load_out) begin
			kind_q  <= hold_kind_q;
			id_q    <= FINGER_W'(hold_id_q);
			pos_x_q <= hold_x_q;
			pos_y_q <= hold_y_q;
			last_q  <= load_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign touch_kind  = kind_q;
	assign finger_id   = id_q;
	assign pos_x       = pos_x_q;
	assign pos_y       = pos_y_q;
	assign last_of_run = last_q;

	`MST_ASSERT_IMPL(a_idle_hold_empty, clk, arst_n, state_q == S_IDLE, !hold_v_q)
	`MST_ASSERT_NEXT(a_frame_closed, clk, arst_n, state_q == S_FLUSH && state_d == S_IDLE, pending_q == '0)
	`MST_ASSERT_IMPL(a_up_at_origin, clk, arst_n, out_valid_q && kind_q == KIND_UP, pos_x_q == '0 && pos_y_q == '0)
	`MST_ASSERT_IMPL(a_div_in_walk, clk, arst_n, drsp.done, state_q == S_DIVX || state_q == S_DIVY)
endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for multitouch_slot_event_tracker_top: drives touch event frames,
// predicts the down, motion and up reports per sync and checks every result beat.
// Depends on mst_pkg and multitouch_slot_event_tracker_top.

module testbench;
	import mst_pkg::*;

	localparam int SLOT_COUNT = 16;
	localparam int POS_MAX = (1 << POS_W) - 1;
	localparam int PHASE_EVENTS = 48;
	localparam int LAST_PHASE = 7;
	localparam int WALK_CYCLES = 1300;
	localparam int QUIET_LIMIT = 20000;
	localparam int REPORT_LIMIT = 10;

	// Event types and codes that the block must ignore.
	localparam logic [4:0] EV_KEY = 5'd1;
	localparam logic [4:0] EV_TYPE_MAX = 5'd31;
	localparam logic [9:0] CODE_SYN_CONFIG = 10'h001;
	localparam logic [9:0] CODE_ABS_MT_TOUCH_MAJOR = 10'h030;
	localparam logic [9:0] CODE_MAX = 10'd767;

	typedef struct packed {
		logic [4:0]  ev_type;
		logic [9:0]  ev_code;
		logic [31:0] ev_value;
	} sensor_event_t;

	typedef struct packed {
		logic [1:0]          kind;
		logic [FINGER_W-1:0] finger;
		logic [POS_W-1:0]    x;
		logic [POS_W-1:0]    y;
		logic                last;
	} touch_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [4:0] event_type = '0;
	logic [9:0] event_code = '0;
	logic signed [31:0] event_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] touch_kind;
	logic [FINGER_W-1:0] finger_id;
	logic [POS_W-1:0] pos_x;
	logic [POS_W-1:0] pos_y;
	logic last_of_run;

	multitouch_slot_event_tracker_top #(
		.MAX_SLOTS(SLOT_COUNT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.event_type(event_type),
		.event_code(event_code),
		.event_value(event_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.touch_kind(touch_kind),
		.finger_id(finger_id),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.last_of_run(last_of_run)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Calibration as the block should hold it.
	logic [SCREEN_W-1:0] cfg_width = SCREEN_WIDTH_RESET;
	logic [SCREEN_W-1:0] cfg_height = SCREEN_HEIGHT_RESET;
	logic [RAW_W-1:0] cfg_x_limit = LIMIT_RESET;
	logic [RAW_W-1:0] cfg_y_limit = LIMIT_RESET;
	logic signed [SCREEN_W-1:0] cfg_off_x = '0;
	logic signed [SCREEN_W-1:0] cfg_off_y = '0;

	// Slot tracking state of the decoder.
	logic [FINGER_W-1:0] sel_slot = '0;
	logic sel_ok = 1'b1;
	logic [SLOT_COUNT-1:0] frame_mask = '0;
	logic [RAW_W-1:0] frame_raw_x [SLOT_COUNT];
	logic [RAW_W-1:0] frame_raw_y [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] touching = '0;
	logic [POS_W-1:0] shown_x [SLOT_COUNT];
	logic [POS_W-1:0] shown_y [SLOT_COUNT];

	sensor_event_t event_q [$];
	sensor_event_t next_event;
	touch_t touch_expect_q [$];
	touch_t expected_touch;

	// Stimulus generator memory: fingers held down and their last raw positions.
	logic [SLOT_COUNT-1:0] held_set = '0;
	int gen_raw_x [SLOT_COUNT];
	int gen_raw_y [SLOT_COUNT];

	int send_gap_pct = 0;
	int recv_gap_pct = 0;
	int fail_count = 0;
	int quiet_cycles = 0;

	function automatic void note_failure(string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT) begin
			$display("%s", msg);
		end
	endfunction

	function automatic logic [POS_W-1:0] scale_to_screen(logic [RAW_W-1:0] raw,
		logic [SCREEN_W-1:0] screen, logic [RAW_W-1:0] limit,
		logic signed [SCREEN_W-1:0] off);
		longint v;
		longint hi;
		v = longint'(raw) * longint'(screen) / ((limit == 0) ? 64'sd1 : longint'(limit))
			+ longint'(off);
		hi = longint'(screen) - 1;
		if (hi > POS_MAX) begin
			hi = POS_MAX;
		end
		if (v > hi) begin
			v = hi;
		end
		if (v < 0) begin
			v = 0;
		end
		return v[POS_W-1:0];
	endfunction

	function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx,
		logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_SCREEN_WIDTH: cfg_width = data[SCREEN_W-1:0];
			REG_SCREEN_HEIGHT: cfg_height = data[SCREEN_W-1:0];
			REG_TOUCH_X_LIMIT: cfg_x_limit = data[RAW_W-1:0];
			REG_TOUCH_Y_LIMIT: cfg_y_limit = data[RAW_W-1:0];
			REG_OFFSET_X: cfg_off_x = data[SCREEN_W-1:0];
			REG_OFFSET_Y: cfg_off_y = data[SCREEN_W-1:0];
			default: ;
		endcase
	endfunction

	// Updates the slot state for one accepted event and queues the touches a sync reports.
	function automatic void track_event(logic [4:0] ev_type, logic [9:0] ev_code,
		logic signed [31:0] ev_value);
		logic [RAW_W-1:0] raw;
		logic [POS_W-1:0] px;
		logic [POS_W-1:0] py;
		touch_t cur;
		touch_t run [$];
		if (ev_type == EV_ABS) begin
			if (ev_code == CODE_SLOT) begin
				if (ev_value >= 0 && ev_value < SLOT_COUNT) begin
					sel_slot = ev_value[FINGER_W-1:0];
					sel_ok = 1'b1;
				end else begin
					sel_ok = 1'b0;
				end
			end else if ((ev_code == CODE_POS_X || ev_code == CODE_POS_Y) && sel_ok) begin
				if (ev_value < 0) begin
					raw = '0;
				end else if (ev_value > 65535) begin
					raw = '1;
				end else begin
					raw = ev_value[RAW_W-1:0];
				end
				// The first coordinate of a slot in a frame clears the other one.
				if (!frame_mask[sel_slot]) begin
					frame_mask[sel_slot] = 1'b1;
					frame_raw_x[sel_slot] = '0;
					frame_raw_y[sel_slot] = '0;
				end
				if (ev_code == CODE_POS_X) begin
					frame_raw_x[sel_slot] = raw;
				end else begin
					frame_raw_y[sel_slot] = raw;
				end
			end
		end else if (ev_type == EV_SYN && ev_code == CODE_SYN_REPORT) begin
			for (int s = 0; s < SLOT_COUNT; s++) begin
				if (frame_mask[s]) begin
					px = scale_to_screen(frame_raw_x[s], cfg_width, cfg_x_limit, cfg_off_x);
					py = scale_to_screen(frame_raw_y[s], cfg_height, cfg_y_limit, cfg_off_y);
					if (!touching[s] || shown_x[s] != px || shown_y[s] != py) begin
						cur.kind = touching[s] ? KIND_MOTION : KIND_DOWN;
						cur.finger = FINGER_W'(s);
						cur.x = px;
						cur.y = py;
						cur.last = 1'b0;
						run.insert(run.size(), cur);
					end
					touching[s] = 1'b1;
					shown_x[s] = px;
					shown_y[s] = py;
				end
			end
			for (int s = 0; s < SLOT_COUNT; s++) begin
				if (touching[s] && !frame_mask[s]) begin
					cur.kind = KIND_UP;
					cur.finger = FINGER_W'(s);
					cur.x = '0;
					cur.y = '0;
					cur.last = 1'b0;
					run.insert(run.size(), cur);
					touching[s] = 1'b0;
				end
			end
			frame_mask = '0;
			foreach (run[i]) begin
				cur = run[i];
				cur.last = (i == run.size() - 1);
				touch_expect_q.insert(touch_expect_q.size(), cur);
			end
		end
	endfunction

	function automatic void queue_event(logic [4:0] t, logic [9:0] c, logic [31:0] v);
		sensor_event_t e;
		e.ev_type = t;
		e.ev_code = c;
		e.ev_value = v;
		event_q.insert(event_q.size(), e);
	endfunction

	function automatic int pick_raw(int limit);
		int v;
		case ($urandom_range(15))
			0: v = 0;
			1: v = limit;
			2: v = 65535;
			3: v = $urandom();
			4: v = $urandom_range(65536, 1000000);
			default: v = $urandom_range(limit);
		endcase
		return v;
	endfunction

	// Events that the block should ignore or that select a slot out of range.
	function automatic void queue_noise();
		logic [9:0] c;
		int v;
		case ($urandom_range(4))
			0: queue_event(5'($urandom_range(31)), 10'($urandom_range(CODE_MAX)), $urandom());
			1: begin
				if ($urandom_range(1)) begin
					v = $urandom_range(SLOT_COUNT, 63);
				end else begin
					v = $urandom() | 32'h8000_0000;
				end
				queue_event(EV_ABS, CODE_SLOT, v);
				queue_event(EV_ABS, $urandom_range(1) ? CODE_POS_X : CODE_POS_Y,
					$urandom_range(4095));
			end
			2: queue_event(EV_SYN, 10'($urandom_range(1, CODE_MAX)), $urandom());
			3: begin
				c = 10'($urandom_range(CODE_MAX));
				if (c == CODE_SLOT || c == CODE_POS_X || c == CODE_POS_Y) begin
					c = CODE_ABS_MT_TOUCH_MAJOR;
				end
				queue_event(EV_ABS, c, $urandom());
			end
			default: queue_event(5'($urandom_range(4, 31)), 10'($urandom_range(CODE_MAX)),
				$urandom());
		endcase
	endfunction

	// One frame: every held finger reports its slot and position, then a sync closes it.
	function automatic void queue_frame(inout int counted);
		int pick;
		int first;
		int s;
		int order;
		pick = $urandom_range(99);
		if (pick < 5) begin
			held_set = '1;
		end else if (pick < 10) begin
			held_set = '0;
		end else begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				held_set[i] = held_set[i] ? ($urandom_range(4) != 0) : ($urandom_range(99) < 5);
			end
		end
		first = $urandom_range(SLOT_COUNT - 1);
		for (int i = 0; i < SLOT_COUNT; i++) begin
			s = (first + i) % SLOT_COUNT;
			if (held_set[s]) begin
				if ($urandom_range(9) == 0) begin
					queue_noise();
				end
				queue_event(EV_ABS, CODE_SLOT, s);
				counted++;
				// A quarter of the time the finger stays where it was.
				if ($urandom_range(3) != 0) begin
					gen_raw_x[s] = pick_raw(cfg_x_limit);
					gen_raw_y[s] = pick_raw(cfg_y_limit);
				end
				order = $urandom_range(19);
				if (order == 0) begin
					queue_event(EV_ABS, CODE_POS_X, gen_raw_x[s]);
					counted++;
				end else if (order == 1) begin
					queue_event(EV_ABS, CODE_POS_Y, gen_raw_y[s]);
					counted++;
				end else if (order < 12) begin
					queue_event(EV_ABS, CODE_POS_X, gen_raw_x[s]);
					queue_event(EV_ABS, CODE_POS_Y, gen_raw_y[s]);
					counted += 2;
					if (order == 2) begin
						queue_event(EV_ABS, CODE_POS_X, gen_raw_x[s]);
						counted++;
					end
				end else begin
					queue_event(EV_ABS, CODE_POS_Y, gen_raw_y[s]);
					queue_event(EV_ABS, CODE_POS_X, gen_raw_x[s]);
					counted += 2;
				end
			end
		end
		if ($urandom_range(9) == 0) begin
			queue_noise();
		end
		queue_event(EV_SYN, CODE_SYN_REPORT, ($urandom_range(3) == 0) ? $urandom() : 0);
		counted++;
	endfunction

	task automatic wait_for_results();
		while (event_q.size() != 0 || in_valid) begin
			@(posedge clk);
		end
		while (touch_expect_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Leaves cfg_valid high; the caller lowers it after the last write.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		apply_setting(idx, CFG_DATA_W'(value));
	endtask

	task automatic configure(int phase);
		int w;
		int h;
		int xl;
		int yl;
		int ox;
		int oy;
		case (phase)
			1: begin
				w = 8192; h = 8192; xl = 1; yl = 1; ox = 8191; oy = -8192;
			end
			2: begin
				w = 1; h = 1; xl = 65535; yl = 65535; ox = -8192; oy = 8191;
			end
			3: begin
				w = 8192; h = 8191; xl = 65535; yl = 65535; ox = 0; oy = 0;
			end
			default: begin
				w = ($urandom_range(3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8192);
				h = ($urandom_range(3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8192);
				xl = $urandom_range(1) ? $urandom_range(1, 4095) : $urandom_range(1, 65535);
				yl = $urandom_range(1) ? $urandom_range(1, 4095) : $urandom_range(1, 65535);
				ox = $urandom_range(1) ? int'($urandom_range(400)) - 200
					: int'($urandom_range(16383)) - 8192;
				oy = $urandom_range(1) ? int'($urandom_range(400)) - 200
					: int'($urandom_range(16383)) - 8192;
			end
		endcase
		write_reg(REG_SCREEN_WIDTH, w);
		write_reg(REG_SCREEN_HEIGHT, h);
		write_reg(REG_TOUCH_X_LIMIT, xl);
		write_reg(REG_TOUCH_Y_LIMIT, yl);
		write_reg(REG_OFFSET_X, ox);
		write_reg(REG_OFFSET_Y, oy);
		cfg_valid <= 1'b0;
	endtask

	// Event driver: a beat is taken when in_valid is high and in_stall is low.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				track_event(event_type, event_code, event_value);
			end
			if (!in_valid || !in_stall) begin
				if (event_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					next_event = event_q.pop_front();
					in_valid <= 1'b1;
					event_type <= next_event.ev_type;
					event_code <= next_event.ev_code;
					event_value <= next_event.ev_value;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (touch_expect_q.size() == 0) begin
					note_failure($sformatf("unexpected result: kind %0d finger %0d x %0d y %0d last %0b",
						touch_kind, finger_id, pos_x, pos_y, last_of_run));
				end else begin
					expected_touch = touch_expect_q.pop_front();
					if (touch_kind !== expected_touch.kind || finger_id !== expected_touch.finger
						|| pos_x !== expected_touch.x || pos_y !== expected_touch.y
						|| last_of_run !== expected_touch.last) begin
						note_failure($sformatf({"result mismatch: expected kind %0d finger %0d",
							" x %0d y %0d last %0b, got kind %0d finger %0d x %0d y %0d last %0b"},
							expected_touch.kind, expected_touch.finger, expected_touch.x,
							expected_touch.y, expected_touch.last, touch_kind, finger_id, pos_x,
							pos_y, last_of_run));
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_gap_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == QUIET_LIMIT) begin
				$display("multitouch_slot_event_tracker_top regression: fail");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int counted;
		bit paused;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		send_gap_pct = 22;
		recv_gap_pct = 45;

		// Directed frames under the reset calibration.
		queue_event(EV_ABS, CODE_POS_X, 4095);
		queue_event(EV_SYN, CODE_SYN_REPORT, 0);
		queue_event(EV_ABS, CODE_SLOT, SLOT_COUNT - 1);
		queue_event(EV_ABS, CODE_POS_Y, 32'h7FFF_FFFF);
		queue_event(EV_ABS, CODE_POS_X, 32'h8000_0000);
		queue_event(EV_ABS, CODE_SLOT, SLOT_COUNT);
		queue_event(EV_ABS, CODE_POS_X, 100);
		queue_event(EV_ABS, CODE_SLOT, -1);
		queue_event(EV_ABS, CODE_POS_Y, 5);
		queue_event(EV_ABS, CODE_ABS_MT_TOUCH_MAJOR, 1);
		queue_event(EV_KEY, CODE_SYN_REPORT, 0);
		queue_event(EV_SYN, CODE_SYN_CONFIG, 0);
		queue_event(EV_SYN, CODE_SYN_REPORT, 0);
		// Same position again: no result at all for this sync.
		queue_event(EV_ABS, CODE_SLOT, SLOT_COUNT - 1);
		queue_event(EV_ABS, CODE_POS_X, 0);
		queue_event(EV_ABS, CODE_POS_Y, 65535);
		queue_event(EV_SYN, CODE_SYN_REPORT, 0);
		queue_event(EV_ABS, CODE_SLOT, 3);
		queue_event(EV_ABS, CODE_POS_Y, 2048);
		queue_event(EV_ABS, CODE_POS_X, 65536);
		queue_event(EV_ABS, CODE_SLOT, SLOT_COUNT - 1);
		queue_event(EV_ABS, CODE_POS_X, 2000);
		queue_event(EV_SYN, CODE_SYN_REPORT, 32'hFFFF_FFFF);
		queue_event(EV_SYN, CODE_SYN_REPORT, 0);
		queue_event(EV_TYPE_MAX, CODE_MAX, 32'h7FFF_FFFF);
		wait_for_results();

		paused = 1'b0;
		for (int phase = 1; phase <= LAST_PHASE; phase++) begin
			if (phase == 3) begin
				send_gap_pct = 45;
				recv_gap_pct = 22;
			end else if (phase == 5) begin
				send_gap_pct = 0;
				recv_gap_pct = 0;
			end
			// A sync that reports nothing may still be walking the slots.
			repeat (WALK_CYCLES) @(posedge clk);
			configure(phase);
			counted = 0;
			while (counted < PHASE_EVENTS) begin
				queue_frame(counted);
				if (phase == 4 && !paused && counted >= PHASE_EVENTS / 2) begin
					wait_for_results();
					paused = 1'b1;
				end
			end
			wait_for_results();
		end

		repeat (WALK_CYCLES) @(posedge clk);
		if (fail_count == 0 && touch_expect_q.size() == 0) begin
			$display("multitouch_slot_event_tracker_top regression: pass");
		end else begin
			$display("multitouch_slot_event_tracker_top regression: fail");
		end
		$finish;
	end

endmodule

// File: multitouch_slot_event_tracker_top.f
+incdir+hdl
hdl/mst_pkg.sv
hdl/mst_ram.sv
hdl/mst_scale_div.sv
hdl/multitouch_slot_event_tracker_top.sv
dv/testbench.sv
